/* rtl/tqws_pkg.sv */
`default_nettype none

package tqws_pkg;

  localparam int unsigned QueueDepthDefault = 512;
  localparam logic [7:0] BurstLimitRst = 8'd10;
  localparam logic [8:0] ServiceCountRst = 9'd0;

  typedef enum logic [1:0] {
    OP_ENQ_HIGH = 2'd0,
    OP_ENQ_LOW  = 2'd1,
    OP_SERVE    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_FULL    = 3'd2,
    ST_SERVED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic {
    REG_BURST_LIMIT   = 1'b0,
    REG_SERVICE_COUNT = 1'b1
  } reg_e;

  typedef struct packed {
    op_e         op;
    logic [30:0] requester_id;
    logic [7:0]  service_index;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [30:0] served_id;
    logic [7:0]  served_service;
    logic        served_low;
  } rsp_t;

  typedef struct packed {
    logic [30:0] id;
    logic [7:0]  svc;
  } entry_t;

  typedef struct packed {
    logic [7:0] high_burst_limit;
    logic [8:0] service_count;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  typedef struct packed {
    logic    done;
    status_e status;
    logic    from_low;
  } meta_t;

endpackage

`default_nettype wire

/* rtl/tqws_cfg.sv */
`default_nettype none

module tqws_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output tqws_pkg::cfg_t     cfg_o
);

  tqws_pkg::cfg_t cfg_d, cfg_q;
  tqws_pkg::reg_e sel;

  // word select, byte offset bits ignored
  assign sel = tqws_pkg::reg_e'(paddr[2]);
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite && pready) begin
      unique case (sel)
        tqws_pkg::REG_BURST_LIMIT:   cfg_d.high_burst_limit = pwdata[7:0];
        tqws_pkg::REG_SERVICE_COUNT: cfg_d.service_count = pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      tqws_pkg::REG_BURST_LIMIT:   prdata = {24'd0, cfg_q.high_burst_limit};
      tqws_pkg::REG_SERVICE_COUNT: prdata = {23'd0, cfg_q.service_count};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_burst_limit <= tqws_pkg::BurstLimitRst;
      cfg_q.service_count <= tqws_pkg::ServiceCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/tqws_queue.sv */
`default_nettype none

module tqws_queue #(
  parameter int unsigned Depth = tqws_pkg::QueueDepthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tqws_pkg::queue_ctl_t  ctl_i,
  input  wire tqws_pkg::entry_t      wr_data_i,
  output tqws_pkg::queue_stat_t      stat_o,
  output tqws_pkg::entry_t           rd_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);

  tqws_pkg::entry_t mem [Depth];
  tqws_pkg::entry_t rd_q;

  logic [PtrW-1:0]  head_d, head_q, tail_d, tail_q;
  logic [FillW-1:0] fill_d, fill_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign stat_o.empty = (fill_q == '0);
  assign stat_o.full  = (fill_q == FillW'(Depth));

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (ctl_i.push) begin
      tail_d = next_ptr(tail_q);
      fill_d = fill_q + FillW'(1);
    end else if (ctl_i.pop) begin
      head_d = next_ptr(head_q);
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // one port written at tail, one read at head, registered read data
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= wr_data_i;
    end
    if (ctl_i.pop) begin
      rd_q <= mem[head_q];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

/* rtl/tqws_sched.sv */
`default_nettype none

module tqws_sched (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire tqws_pkg::req_t         req_i,
  input  wire tqws_pkg::cfg_t         cfg_i,
  input  wire tqws_pkg::queue_stat_t  high_stat_i,
  input  wire tqws_pkg::queue_stat_t  low_stat_i,
  output tqws_pkg::queue_ctl_t        high_ctl_o,
  output tqws_pkg::queue_ctl_t        low_ctl_o,
  output tqws_pkg::meta_t             meta_o
);

  logic [7:0] burst_d, burst_q;
  tqws_pkg::meta_t meta_d, meta_q;
  logic unknown, reached, tgt_full;

  assign unknown  = ({1'b0, req_i.service_index} >= cfg_i.service_count);
  assign reached  = (burst_q >= cfg_i.high_burst_limit);
  assign tgt_full = (req_i.op == tqws_pkg::OP_ENQ_HIGH) ? high_stat_i.full : low_stat_i.full;

  always_comb begin
    burst_d = burst_q;
    high_ctl_o = '0;
    low_ctl_o = '0;
    meta_d.done = accept_i;
    meta_d.status = tqws_pkg::ST_EMPTY;
    meta_d.from_low = 1'b0;
    unique case (req_i.op) inside
      tqws_pkg::OP_ENQ_HIGH, tqws_pkg::OP_ENQ_LOW: begin
        if (unknown) begin
          meta_d.status = tqws_pkg::ST_UNKNOWN;
        end else if (tgt_full) begin
          meta_d.status = tqws_pkg::ST_FULL;
        end else begin
          meta_d.status = tqws_pkg::ST_QUEUED;
          if (req_i.op == tqws_pkg::OP_ENQ_HIGH) begin
            high_ctl_o.push = accept_i;
          end else begin
            low_ctl_o.push = accept_i;
          end
        end
      end
      tqws_pkg::OP_SERVE: begin
        if (!high_stat_i.empty && !reached) begin
          meta_d.status = tqws_pkg::ST_SERVED;
          high_ctl_o.pop = accept_i;
          if (accept_i) begin
            burst_d = burst_q + 8'd1;
          end
        end else if (!low_stat_i.empty) begin
          meta_d.status = tqws_pkg::ST_SERVED;
          meta_d.from_low = 1'b1;
          low_ctl_o.pop = accept_i;
          if (accept_i && reached) begin
            burst_d = '0;
          end
        end else if (!high_stat_i.empty) begin
          // burst used up but nothing waits low: keep count, serve high
          meta_d.status = tqws_pkg::ST_SERVED;
          high_ctl_o.pop = accept_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= '0;
      meta_q.done <= 1'b0;
      meta_q.status <= tqws_pkg::ST_EMPTY;
      meta_q.from_low <= 1'b0;
    end else begin
      burst_q <= burst_d;
      meta_q <= meta_d;
    end
  end

  assign meta_o = meta_q;

endmodule

`default_nettype wire

/* rtl/two_queue_weighted_server.sv */
`default_nettype none

// Two request queues, high and low priority, share one server. An enqueue request
// is checked against service_count and a full queue, then pushed into its queue;
// a serve request takes up to high_burst_limit high-priority entries in a row
// before one low-priority entry, and takes a high entry even past the burst when
// the low queue is empty. A request is taken in every cycle (busy stays low), and
// its single result shows on rsp_o in the cycle after acceptance, qualified by
// done_o for a single cycle; the receiver cannot stall, so it must take each result
// as it appears. Status and served entry are registered, the entry in the read port
// of its queue memory. The queue memories need no clearing after reset: an entry is
// only read while its queue holds it. The user must write configuration over the APB
// port only while no request is in flight; the block itself does not enforce it.
module two_queue_weighted_server #(
  parameter int unsigned HIGH_DEPTH = tqws_pkg::QueueDepthDefault,
  parameter int unsigned LOW_DEPTH  = tqws_pkg::QueueDepthDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // request side
  input  wire logic            start,
  output logic                 busy,
  input  wire tqws_pkg::req_t  req_i,
  // result side
  output logic                 done_o,
  output tqws_pkg::rsp_t       rsp_o,
  // configuration
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  tqws_pkg::cfg_t        cfg;
  tqws_pkg::queue_ctl_t  high_ctl, low_ctl;
  tqws_pkg::queue_stat_t high_stat, low_stat;
  tqws_pkg::entry_t      wr_entry, high_rd, low_rd, served;
  tqws_pkg::meta_t       meta;
  logic                  accept;
  logic                  is_served;

  // nothing ever holds the input off, so every request is accepted
  assign busy = 1'b0;
  assign accept = start && !busy;

  assign wr_entry.id  = req_i.requester_id;
  assign wr_entry.svc = req_i.service_index;

  tqws_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // decision logic and burst counter
  tqws_sched u_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .high_stat_i (high_stat),
    .low_stat_i  (low_stat),
    .high_ctl_o  (high_ctl),
    .low_ctl_o   (low_ctl),
    .meta_o      (meta)
  );

  // high-priority queue
  tqws_queue #(
    .Depth (HIGH_DEPTH)
  ) u_high_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (high_ctl),
    .wr_data_i (wr_entry),
    .stat_o    (high_stat),
    .rd_data_o (high_rd)
  );

  // low-priority queue
  tqws_queue #(
    .Depth (LOW_DEPTH)
  ) u_low_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (low_ctl),
    .wr_data_i (wr_entry),
    .stat_o    (low_stat),
    .rd_data_o (low_rd)
  );

  // result: pick the queue read port that was popped, zero when nothing served
  assign is_served = (meta.status == tqws_pkg::ST_SERVED);
  assign served = meta.from_low ? low_rd : high_rd;

  assign done_o               = meta.done;
  assign rsp_o.status         = meta.status;
  assign rsp_o.served_id      = is_served ? served.id : '0;
  assign rsp_o.served_service = is_served ? served.svc : '0;
  assign rsp_o.served_low     = is_served && meta.from_low;

`ifndef NO_ASSERTIONS
  // each accepted request yields exactly one result on the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(accept))
    else $error("result strobe does not follow accepted request");

  // at most one queue is popped per serve request
  a_single_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(high_ctl.pop && low_ctl.pop))
    else $error("both queues popped");

  // never pop an empty queue or push a full one
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (high_ctl.pop |-> !high_stat.empty) and (low_ctl.pop |-> !low_stat.empty))
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (high_ctl.push |-> !high_stat.full) and (low_ctl.push |-> !low_stat.full))
    else $error("push into full queue");

  // a low-queue result must come from a pop of the low queue
  a_low_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.served_low) |-> $past(low_ctl.pop))
    else $error("low result without low pop");
`endif

endmodule

`default_nettype wire
